// ===== src/wsfp_pkg.sv =====
`timescale 1ns / 1ps

package wsfp_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned HdrCntW = 4;
  localparam int unsigned KeyIdxW = 2;

  // second header byte length codes
  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  // extended length and key byte counts
  localparam logic [HdrCntW-1:0] ExtLen16Bytes = 4'd2;
  localparam logic [HdrCntW-1:0] ExtLen64Bytes = 4'd8;
  localparam logic [HdrCntW-1:0] KeyBytes      = 4'd4;

  // result kinds
  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  // parser phases
  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

endpackage

// ===== src/wsfp_byte_if.sv =====
`timescale 1ns / 1ps

interface wsfp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [wsfp_pkg::ByteW-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/wsfp_result_if.sv =====
`timescale 1ns / 1ps

interface wsfp_result_if;
  logic                         valid;
  logic                         ready;
  logic                         item_kind;
  logic                         final_fragment;
  logic [wsfp_pkg::OpW-1:0]     opcode;
  logic                         mask_present;
  logic [wsfp_pkg::LenW-1:0]    length_in_bytes;
  logic [wsfp_pkg::ByteW-1:0]   payload_byte;
  logic                         frame_end;

  modport source (
    output valid, output item_kind, output final_fragment, output opcode,
    output mask_present, output length_in_bytes, output payload_byte,
    output frame_end, input ready
  );
  modport sink (
    input valid, input item_kind, input final_fragment, input opcode,
    input mask_present, input length_in_bytes, input payload_byte,
    input frame_end, output ready
  );
endinterface

// ===== src/websocket_frame_parser_top.sv =====
`timescale 1ns / 1ps

// WebSocket frame parser: takes one stream byte per clock and returns one
// header request when a frame header completes (FIN, opcode, mask flag and
// decoded 64-bit length) and then one request per unmasked payload byte,
// with frame_end on the last request of each frame (on the header itself
// for an empty frame). Header bytes other than the one that completes the
// header give no request. Each accepted byte is handled combinationally
// and its request sits in the output register from the next cycle; input
// ready drops only while that register is full and the sink holds ready low,
// so the sustained rate is one byte per clock while the sink keeps ready high.
module websocket_frame_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  wsfp_byte_if.sink           in_i,
  wsfp_result_if.source       out_o
);

  // parser state
  wsfp_pkg::phase_e                  phase_q, phase_d;
  logic [wsfp_pkg::HdrCntW-1:0]      hdr_left_q, hdr_left_d;
  logic                              fin_q, fin_d;
  logic [wsfp_pkg::OpW-1:0]          op_q, op_d;
  logic                              mask_q, mask_d;
  logic [wsfp_pkg::LenW-1:0]         len_q, len_d;
  logic [wsfp_pkg::KeyW-1:0]         key_q, key_d;
  logic [wsfp_pkg::LenW-1:0]         rem_q, rem_d;
  logic [wsfp_pkg::KeyIdxW-1:0]      kidx_q, kidx_d;

  // output register
  logic                              out_valid_q, out_valid_d;
  logic                              out_kind_q;
  logic                              out_fin_q;
  logic [wsfp_pkg::OpW-1:0]          out_op_q;
  logic                              out_mask_q;
  logic [wsfp_pkg::LenW-1:0]         out_len_q;
  logic [wsfp_pkg::ByteW-1:0]        out_byte_q;
  logic                              out_end_q;

  // per-byte result
  logic                              accept;
  logic                              after_len;
  logic                              finish;
  logic                              res_valid;
  logic                              res_kind;
  logic [wsfp_pkg::ByteW-1:0]        res_byte;
  logic                              res_end;
  logic [wsfp_pkg::ByteW-1:0]        key_byte;
  logic [wsfp_pkg::ByteW-1:0]        b;

  assign b         = in_i.data_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;

  // key byte for the current payload position, most significant first
  always_comb begin
    unique case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // next state and result for one byte
  always_comb begin
    phase_d    = phase_q;
    hdr_left_d = hdr_left_q;
    fin_d      = fin_q;
    op_d       = op_q;
    mask_d     = mask_q;
    len_d      = len_q;
    key_d      = key_q;
    rem_d      = rem_q;
    kidx_d     = kidx_q;
    after_len  = 1'b0;
    finish     = 1'b0;
    res_valid  = 1'b0;
    res_kind   = wsfp_pkg::KindHeader;
    res_byte   = '0;
    res_end    = 1'b0;

    unique case (phase_q)
      wsfp_pkg::PH_SECOND: begin
        mask_d = b[7];
        if (b[6:0] < wsfp_pkg::LenCode16) begin
          len_d     = {{(wsfp_pkg::LenW-7){1'b0}}, b[6:0]};
          after_len = 1'b1;
        end else begin
          len_d      = '0;
          hdr_left_d = (b[6:0] == wsfp_pkg::LenCode16) ? wsfp_pkg::ExtLen16Bytes
                                                       : wsfp_pkg::ExtLen64Bytes;
          phase_d    = wsfp_pkg::PH_EXTLEN;
        end
      end
      wsfp_pkg::PH_EXTLEN: begin
        len_d      = {len_q[wsfp_pkg::LenW-9:0], b};
        hdr_left_d = hdr_left_q - 4'd1;
        after_len  = (hdr_left_d == '0);
      end
      wsfp_pkg::PH_KEY: begin
        key_d      = {key_q[wsfp_pkg::KeyW-9:0], b};
        hdr_left_d = hdr_left_q - 4'd1;
        finish     = (hdr_left_d == '0);
      end
      wsfp_pkg::PH_PAYLOAD: begin
        kidx_d    = kidx_q + 2'd1;
        rem_d     = rem_q - 64'd1;
        res_valid = 1'b1;
        res_kind  = wsfp_pkg::KindPayload;
        res_byte  = mask_q ? (b ^ key_byte) : b;
        res_end   = (rem_d == '0);
        if (res_end) begin
          phase_d = wsfp_pkg::PH_FIRST;
        end
      end
      default: begin
        fin_d   = b[7];
        op_d    = b[3:0];
        phase_d = wsfp_pkg::PH_SECOND;
      end
    endcase

    // length known: collect the key or close the header
    if (after_len) begin
      if (mask_d) begin
        phase_d    = wsfp_pkg::PH_KEY;
        hdr_left_d = wsfp_pkg::KeyBytes;
        key_d      = '0;
      end else begin
        finish = 1'b1;
      end
    end

    // header complete
    if (finish) begin
      rem_d     = len_d;
      kidx_d    = '0;
      res_valid = 1'b1;
      res_kind  = wsfp_pkg::KindHeader;
      res_end   = (len_d == '0);
      phase_d   = res_end ? wsfp_pkg::PH_FIRST : wsfp_pkg::PH_PAYLOAD;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wsfp_pkg::PH_FIRST;
      hdr_left_q <= '0;
      fin_q      <= 1'b0;
      op_q       <= '0;
      mask_q     <= 1'b0;
      len_q      <= '0;
      key_q      <= '0;
      rem_q      <= '0;
      kidx_q     <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      hdr_left_q <= hdr_left_d;
      fin_q      <= fin_d;
      op_q       <= op_d;
      mask_q     <= mask_d;
      len_q      <= len_d;
      key_q      <= key_d;
      rem_q      <= rem_d;
      kidx_q     <= kidx_d;
    end
  end

  // output valid
  assign out_valid_d = accept ? res_valid : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_kind_q <= res_kind;
      out_fin_q  <= fin_d;
      out_op_q   <= op_d;
      out_mask_q <= mask_d;
      out_len_q  <= len_d;
      out_byte_q <= res_byte;
      out_end_q  <= res_end;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.item_kind       = out_kind_q;
  assign out_o.final_fragment  = out_fin_q;
  assign out_o.opcode          = out_op_q;
  assign out_o.mask_present    = out_mask_q;
  assign out_o.length_in_bytes = out_len_q;
  assign out_o.payload_byte    = out_byte_q;
  assign out_o.frame_end       = out_end_q;

  // the payload phase always has bytes left to take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsfp_pkg::PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with zero bytes remaining");

  // header byte counters never sit at zero inside a counted phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsfp_pkg::PH_EXTLEN || phase_q == wsfp_pkg::PH_KEY) |-> hdr_left_q != '0)
    else $error("header byte counter empty in counted phase");

  // the last request of a frame returns the parser to the first header byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid && res_end |=> phase_q == wsfp_pkg::PH_FIRST)
    else $error("frame end without return to first header byte");

  // an accepted byte with a request loads the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid |=> out_valid_q && out_end_q == $past(res_end))
    else $error("request lost from output register");

endmodule
